// ===== design/gvad_pkg.sv =====
// gvad_pkg: shared types and constants of the group-varint adjacency decoder
// no dependencies; imported by gvad_parse, gvad_perm_ram and the top level
`timescale 1ns / 1ps
`default_nettype none

package gvad_pkg;

	localparam int unsigned MAX_DEGREE = 255;
	localparam int unsigned PERM_DEPTH = 256;
	localparam int unsigned PERM_AW = $clog2(PERM_DEPTH);

	typedef enum logic [2:0] {
		ST_VALUE    = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_TRAIL    = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_BADPERM  = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0] neighbor;
		logic [7:0]  slot;
		logic        last;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic               en;
		logic [PERM_AW-1:0] addr;
		logic [7:0]         data;
	} ram_wr_t;

	typedef struct packed {
		logic [PERM_AW-1:0] addr0;
		logic [PERM_AW-1:0] addr1;
	} ram_rd_t;

	// number of bits needed to hold v
	function automatic logic [3:0] bit_width8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== design/gvad_regs.sv =====
// gvad_regs: APB-style configuration register (preserve_order)
// standalone; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module gvad_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        preserve_order
);

	localparam logic [2:0] ADDR_PRESERVE_ORDER = 3'd0;

	logic hit;
	logic preserve_order_q;

	assign hit = (paddr == ADDR_PRESERVE_ORDER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preserve_order_q <= 1'b0;
		end else if (psel && penable && pwrite && hit) begin
			preserve_order_q <= pwdata[0];
		end
	end

	assign prdata = hit ? {31'd0, preserve_order_q} : 32'd0;
	assign preserve_order = preserve_order_q;

endmodule

`default_nettype wire

// ===== design/gvad_perm_ram.sv =====
// gvad_perm_ram: packed permutation store, one write port, two registered read ports
// depends on gvad_pkg for depth and port structs
`timescale 1ns / 1ps
`default_nettype none

module gvad_perm_ram (
	input  logic              clk,
	input  gvad_pkg::ram_wr_t wr,
	input  gvad_pkg::ram_rd_t rd,
	output logic [7:0]        rdata0,
	output logic [7:0]        rdata1
);

	import gvad_pkg::*;

	logic [7:0] mem [PERM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata0 <= mem[rd.addr0];
		rdata1 <= mem[rd.addr1];
	end

endmodule

`default_nettype wire

// ===== design/gvad_parse.sv =====
// gvad_parse: record parser state, group-varint delta decode, slot checks
// depends on gvad_pkg; reads the permutation through gvad_perm_ram
`timescale 1ns / 1ps
`default_nettype none

module gvad_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        rec_byte,
	input  logic              rec_end,
	input  logic              preserve_order,
	input  logic [7:0]        ram_rdata0,
	input  logic [7:0]        ram_rdata1,
	output logic              res_valid,
	output gvad_pkg::result_t res,
	output gvad_pkg::ram_wr_t ram_wr,
	output gvad_pkg::ram_rd_t ram_rd
);

	import gvad_pkg::*;

	typedef enum logic [5:0] {
		PH_DEGREE = 6'b000001,
		PH_PERM   = 6'b000010,
		PH_TAG    = 6'b000100,
		PH_VALUE  = 6'b001000,
		PH_DONE   = 6'b010000,
		PH_SKIP   = 6'b100000
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [7:0]   degree_q, degree_d;
	logic [3:0]   sbits_q, sbits_d;
	logic [7:0]   psize_q, psize_d;
	logic [7:0]   pleft_q, pleft_d;
	logic [7:0]   vidx_q, vidx_d;
	logic [7:0]   tag_q, tag_d;
	logic [1:0]   biv_q, biv_d;
	logic [31:0]  pdelta_q, pdelta_d;
	logic [31:0]  run_q, run_d;
	logic [255:0] seen_q, seen_d;
	logic [2:0]   sh_q;
	logic         hi_ok_q;

	logic         do_fail;
	status_t      fail_st;
	logic         wr_req;
	logic [3:0]   bw;
	logic [7:0]   size;
	logic [1:0]   wfield;
	logic [31:0]  pd_new;
	logic [32:0]  sum33;
	logic [31:0]  nb;
	logic [7:0]   sl;
	logic [7:0]   vidx_inc;
	logic [15:0]  packed_pair;
	logic [15:0]  slot_mask;
	logic [7:0]   slot_mem;

	// read-side address: follows the state the next byte will see
	logic [7:0]   vidx_sel;
	logic [3:0]   sbits_sel;
	logic [7:0]   psize_sel;
	logic [10:0]  bit_pos;

	assign vidx_sel  = fire ? vidx_d : vidx_q;
	assign sbits_sel = fire ? sbits_d : sbits_q;
	assign psize_sel = fire ? psize_d : psize_q;
	assign bit_pos   = 11'({3'd0, vidx_sel} * {7'd0, sbits_sel});
	assign ram_rd.addr0 = bit_pos[10:3];
	assign ram_rd.addr1 = bit_pos[10:3] + 8'd1;

	assign packed_pair = {hi_ok_q ? ram_rdata1 : 8'h00, ram_rdata0} >> sh_q;
	assign slot_mask   = (16'd1 << sbits_q) - 16'd1;
	assign slot_mem    = 8'(packed_pair & slot_mask);

	assign bw   = bit_width8(rec_byte - 8'd1);
	assign size = 8'((12'(rec_byte) * 12'(bw) + 12'd7) >> 3);

	always_comb begin
		phase_d  = phase_q;
		degree_d = degree_q;
		sbits_d  = sbits_q;
		psize_d  = psize_q;
		pleft_d  = pleft_q;
		vidx_d   = vidx_q;
		tag_d    = tag_q;
		biv_d    = biv_q;
		pdelta_d = pdelta_q;
		run_d    = run_q;
		seen_d   = seen_q;
		do_fail  = 1'b0;
		fail_st  = ST_TRUNC;
		wr_req   = 1'b0;
		res_valid = 1'b0;
		res      = '0;
		wfield   = tag_q[{vidx_q[1:0], 1'b0} +: 2];
		pd_new   = pdelta_q | (32'(rec_byte) << {biv_q, 3'b000});
		sum33    = {1'b0, run_q} + {1'b0, pd_new};
		nb       = (vidx_q == 8'd0) ? pd_new : sum33[31:0];
		sl       = (sbits_q != 4'd0) ? slot_mem : vidx_q;
		vidx_inc = vidx_q + 8'd1;

		unique case (phase_q)
			PH_DEGREE: begin
				degree_d = rec_byte;
				seen_d   = '0;
				vidx_d   = '0;
				run_d    = '0;
				tag_d    = '0;
				biv_d    = '0;
				pdelta_d = '0;
				sbits_d  = '0;
				pleft_d  = '0;
				psize_d  = '0;
				if ({1'b0, rec_byte} > 9'(MAX_DEGREE)) begin
					do_fail = 1'b1;
					fail_st = ST_BADPERM;
				end else if (rec_byte == 8'd0) begin
					if (rec_end) begin
						res_valid  = 1'b1;
						res.last   = 1'b1;
						res.status = ST_EMPTY;
					end else begin
						phase_d = PH_DONE;
					end
				end else begin
					if (preserve_order && rec_byte >= 8'd2) begin
						sbits_d = bw;
						psize_d = size;
						pleft_d = size;
						phase_d = PH_PERM;
					end else begin
						phase_d = PH_TAG;
					end
					do_fail = rec_end;
				end
			end
			PH_PERM: begin
				wr_req  = 1'b1;
				pleft_d = pleft_q - 8'd1;
				if (pleft_q == 8'd1) begin
					phase_d = PH_TAG;
				end
				do_fail = rec_end;
			end
			PH_TAG: begin
				tag_d    = rec_byte;
				biv_d    = '0;
				pdelta_d = '0;
				phase_d  = PH_VALUE;
				do_fail  = rec_end;
			end
			PH_VALUE: begin
				if (biv_q != wfield) begin
					biv_d    = biv_q + 2'd1;
					pdelta_d = pd_new;
					do_fail  = rec_end;
				end else begin
					biv_d    = '0;
					pdelta_d = '0;
					// a carry out of a later delta means the neighbor wrapped
					if (vidx_q != 8'd0 && sum33[32]) begin
						do_fail = 1'b1;
						fail_st = ST_OVERFLOW;
					end else begin
						run_d = nb;
						if (sl >= degree_q || seen_q[sl]) begin
							do_fail = 1'b1;
							fail_st = ST_BADPERM;
						end else begin
							seen_d[sl] = 1'b1;
							vidx_d     = vidx_inc;
							if (vidx_inc >= degree_q) begin
								phase_d      = rec_end ? PH_DEGREE : PH_DONE;
								res_valid    = 1'b1;
								res.neighbor = nb;
								res.slot     = sl;
								res.last     = rec_end;
								res.status   = ST_VALUE;
							end else if (rec_end) begin
								do_fail = 1'b1;
							end else begin
								phase_d      = (vidx_inc[1:0] == 2'd0) ? PH_TAG : PH_VALUE;
								res_valid    = 1'b1;
								res.neighbor = nb;
								res.slot     = sl;
								res.status   = ST_VALUE;
							end
						end
					end
				end
			end
			PH_DONE: begin
				do_fail = 1'b1;
				fail_st = ST_TRAIL;
			end
			PH_SKIP: begin
				if (rec_end) begin
					phase_d = PH_DEGREE;
				end
			end
			default: begin
				phase_d = PH_DEGREE;
			end
		endcase

		// error beat ends the record now or swallows the rest of it
		if (do_fail) begin
			res_valid  = 1'b1;
			res        = '0;
			res.last   = 1'b1;
			res.status = fail_st;
			phase_d    = rec_end ? PH_DEGREE : PH_SKIP;
		end

		ram_wr.en   = fire && wr_req;
		ram_wr.addr = psize_q - pleft_q;
		ram_wr.data = rec_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DEGREE;
			degree_q <= '0;
			sbits_q  <= '0;
			psize_q  <= '0;
			pleft_q  <= '0;
			vidx_q   <= '0;
			tag_q    <= '0;
			biv_q    <= '0;
			pdelta_q <= '0;
			run_q    <= '0;
			seen_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			degree_q <= degree_d;
			sbits_q  <= sbits_d;
			psize_q  <= psize_d;
			pleft_q  <= pleft_d;
			vidx_q   <= vidx_d;
			tag_q    <= tag_d;
			biv_q    <= biv_d;
			pdelta_q <= pdelta_d;
			run_q    <= run_d;
			seen_q   <= seen_d;
		end
	end

	// alignment of the slot entry inside the two fetched bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q    <= '0;
			hi_ok_q <= 1'b0;
		end else begin
			sh_q    <= bit_pos[2:0];
			hi_ok_q <= ({1'b0, bit_pos[10:3]} + 9'd1) < {1'b0, psize_sel};
		end
	end

endmodule

`default_nettype wire

// ===== design/groupvarint_adjacency_decoder.sv =====
// Group-varint adjacency record decoder.
// Input channel (in_valid/in_ready): one beat per record byte, record_end on the
// final byte. The first byte is the degree; preserve_order set and a degree of 2
// or more add a packed permutation; then tag bytes and little-endian deltas.
// Output channel (out_valid/out_ready): one beat per decoded neighbor with its
// slot, a last mark and a status; errors give a single beat with last set and
// the rest of the record is dropped up to its final byte.
// A byte waits in the input register, its result beat in the result register.
// Throughput: one byte per cycle unless stalled, set by the byte-wide parser
// step and the two-port permutation store, whose next slot is fetched while a
// byte is parsed.
// A byte may enter while a result beat waits: the input register and result
// register decouple the sides; a held result stalls only bytes that make a beat.
// Reset: parser expects a degree byte, both registers are empty, preserve_order
// is 0. Configuration is an APB-style register at address 0 (bit 0), pready is
// always high; write it only while no record is in flight.
`timescale 1ns / 1ps
`default_nettype none

module groupvarint_adjacency_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  record_byte,
	input  logic        record_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] neighbor,
	output logic [7:0]  slot,
	output logic        last,
	output logic [2:0]  status
);

	import gvad_pkg::*;

	logic       preserve_order;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       fire;
	logic       res_valid;
	result_t    res;
	ram_wr_t    ram_wr;
	ram_rd_t    ram_rd;
	logic [7:0] ram_rdata0;
	logic [7:0] ram_rdata1;

	gvad_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.preserve_order (preserve_order)
	);

	assign pready = 1'b1;

	// a byte moves on unless it makes a beat and the result register is stuck
	assign fire     = valid_s1 && (!res_valid || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	gvad_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.rec_byte       (byte_s1),
		.rec_end        (end_s1),
		.preserve_order (preserve_order),
		.ram_rdata0     (ram_rdata0),
		.ram_rdata1     (ram_rdata1),
		.res_valid      (res_valid),
		.res            (res),
		.ram_wr         (ram_wr),
		.ram_rd         (ram_rd)
	);

	gvad_perm_ram u_perm_ram (
		.clk    (clk),
		.wr     (ram_wr),
		.rd     (ram_rd),
		.rdata0 (ram_rdata0),
		.rdata1 (ram_rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !fire);
			valid_s2 <= (fire && res_valid) || (valid_s2 && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= record_byte;
			end_s1  <= record_end;
		end
		if (fire && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign neighbor  = res_s2.neighbor;
	assign slot      = res_s2.slot;
	assign last      = res_s2.last;
	assign status    = res_s2.status;

`ifndef SYNTH
	a_error_beat_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_VALUE |-> neighbor == 32'd0 && slot == 8'd0 && last)
		else $error("error beat carries payload or lacks last");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("input register lost a byte while stalled");

	a_value_last_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && res.status == ST_VALUE && res.last |-> end_s1)
		else $error("value beat marked last without record end");
`endif

endmodule

`default_nettype wire
